[src/clcd_pkg.sv]
// Shared types, codes and the power-up command table of the character LCD console.
package clcd_pkg;

   localparam logic [2:0] REQ_PUT_CHAR  = 3'd0;
   localparam logic [2:0] REQ_CLEAR     = 3'd1;
   localparam logic [2:0] REQ_COMMIT    = 3'd2;
   localparam logic [2:0] REQ_DISP_CTRL = 3'd3;
   localparam logic [2:0] REQ_CURSOR    = 3'd4;
   localparam logic [2:0] REQ_INIT      = 3'd5;

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_NIBBLE = 2'd1;
   localparam logic [1:0] KIND_WAIT   = 2'd2;

   localparam logic [2:0] WAIT_50US     = 3'd0;
   localparam logic [2:0] WAIT_2MS      = 3'd1;
   localparam logic [2:0] WAIT_5MS      = 3'd2;
   localparam logic [2:0] WAIT_10MS     = 3'd3;
   localparam logic [2:0] WAIT_200MS    = 3'd4;

   localparam logic       RS_CMD  = 1'b0;
   localparam logic       RS_DATA = 1'b1;

   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
   localparam logic [7:0] CMD_DISP_CTRL   = 8'h08;
   localparam logic [7:0] CMD_FUNC_SET    = 8'h20;
   localparam logic [7:0] FUNC_TWO_LINES  = 8'h08;
   localparam logic [7:0] FUNC_FONT_TALL  = 8'h04;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_HOME        = 8'h02;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_SHIFT       = 8'h10;
   localparam logic [7:0] CMD_DISP_ON     = 8'h0C;
   localparam logic [7:0] NIB_WAKE        = 8'h03;
   localparam logic [7:0] NIB_4BIT        = 8'h02;

   localparam logic [3:0] INIT_STEPS = 4'd12;

   typedef struct packed {
      logic [1:0] kind;
      logic       reg_sel;
      logic [7:0] bus_value;
      logic [2:0] wait_code;
   } xfer_type;

   typedef enum logic [2:0] {
      SEL_INIT,
      SEL_LINE_CUR,
      SEL_CHAR,
      SEL_RESTORE,
      SEL_DISP,
      SEL_USER_CUR
   } emit_sel_type;

   typedef struct packed {
      logic         capture;
      logic         put_char;
      logic         clear;
      logic         emit;
      emit_sel_type sel;
      logic [3:0]   init_step;
      logic         last;
      logic         rd_en;
   } cmd_type;

   function automatic xfer_type init_xfer(logic [3:0] step, logic font_tall,
                                          logic multi_line);
      xfer_type x;
      x.kind      = KIND_BYTE;
      x.reg_sel   = RS_CMD;
      x.bus_value = CMD_DISP_CTRL;
      x.wait_code = WAIT_50US;
      case (step)
         4'd0: begin
            x.kind      = KIND_WAIT;
            x.bus_value = NIB_WAKE;
            x.wait_code = WAIT_200MS;
         end
         4'd1, 4'd2, 4'd3: begin
            x.kind      = KIND_NIBBLE;
            x.bus_value = NIB_WAKE;
            x.wait_code = WAIT_5MS;
         end
         4'd4: begin
            x.kind      = KIND_NIBBLE;
            x.bus_value = NIB_4BIT;
            x.wait_code = WAIT_10MS;
         end
         4'd5: x.bus_value = CMD_FUNC_SET | (multi_line ? FUNC_TWO_LINES : 8'h00)
                             | (font_tall ? FUNC_FONT_TALL : 8'h00);
         4'd6: x.bus_value = CMD_DISP_CTRL;
         4'd7: begin
            x.bus_value = CMD_CLEAR;
            x.wait_code = WAIT_2MS;
         end
         4'd8:  x.bus_value = CMD_ENTRY_MODE;
         4'd9:  x.bus_value = CMD_SHIFT;
         4'd10: x.bus_value = CMD_DISP_ON;
         4'd11: begin
            x.bus_value = CMD_HOME;
            x.wait_code = WAIT_2MS;
         end
         default: x.bus_value = CMD_DISP_CTRL;
      endcase
      return x;
   endfunction

endpackage

[src/clcd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module clcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/clcd_ctrl.sv]
// Request sequencer: decodes requests and steps through init and commit transfers.
module clcd_ctrl import clcd_pkg::*; #(
   parameter int NUM_LINES   = 2,
   parameter int NUM_COLUMNS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [2:0]                                   req_type,
   input  logic                                         out_free,
   output cmd_type                                      cmd,
   output logic [(NUM_LINES > 1 ? $clog2(NUM_LINES) : 1)-1:0] cmd_line,
   output logic [$clog2(NUM_LINES*NUM_COLUMNS)-1:0]     rd_addr
);

   localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int CW = $clog2(NUM_COLUMNS);
   localparam int AW = $clog2(NUM_LINES*NUM_COLUMNS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_INIT,
      ST_LINE,
      ST_CHARS,
      ST_RESTORE
   } state_type;

   state_type    state_ff, state_in;
   emit_sel_type single_ff, single_in;
   logic [3:0]   step_ff, step_in;
   logic [LW-1:0] line_ff, line_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] idx_ff, idx_in;

   always_comb begin
      state_in  = state_ff;
      single_in = single_ff;
      step_in   = step_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      cmd.sel   = SEL_INIT;
      req_ready = 1'b0;
      rd_addr   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            line_in   = '0;
            col_in    = '0;
            idx_in    = '0;
            step_in   = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_PUT_CHAR: cmd.put_char = 1'b1;
                  REQ_CLEAR:    cmd.clear = 1'b1;
                  REQ_COMMIT:   state_in = ST_LINE;
                  REQ_DISP_CTRL: begin
                     single_in = SEL_DISP;
                     state_in  = ST_SINGLE;
                  end
                  REQ_CURSOR: begin
                     single_in = SEL_USER_CUR;
                     state_in  = ST_SINGLE;
                  end
                  REQ_INIT: begin
                     cmd.clear = 1'b1;
                     state_in  = ST_INIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = single_ff;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            if (out_free) begin
               cmd.emit      = 1'b1;
               cmd.sel       = SEL_INIT;
               cmd.init_step = step_ff;
               step_in       = step_ff + 4'd1;
               if (step_ff == INIT_STEPS - 4'd1) begin
                  state_in = ST_LINE;
               end
            end
         end
         ST_LINE: begin
            if (out_free) begin
               cmd.emit  = 1'b1;
               cmd.sel   = SEL_LINE_CUR;
               cmd.rd_en = 1'b1;
               rd_addr   = idx_ff;
               state_in  = ST_CHARS;
            end
         end
         ST_CHARS: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_CHAR;
               idx_in   = AW'(idx_ff + 1'b1);
               if (col_ff == CW'(NUM_COLUMNS - 1)) begin
                  col_in = '0;
                  if (line_ff == LW'(NUM_LINES - 1)) begin
                     state_in = ST_RESTORE;
                  end else begin
                     line_in  = LW'(line_ff + 1'b1);
                     state_in = ST_LINE;
                  end
               end else begin
                  col_in    = CW'(col_ff + 1'b1);
                  cmd.rd_en = 1'b1;
                  rd_addr   = AW'(idx_ff + 1'b1);
               end
            end
         end
         ST_RESTORE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = SEL_RESTORE;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign cmd_line = line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         single_ff <= SEL_DISP;
         step_ff   <= '0;
         line_ff   <= '0;
         col_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         single_ff <= single_in;
         step_ff   <= step_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         idx_ff    <= idx_in;
      end
   end

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("transfer issued while output register is occupied");

   a_index_tracks_position: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHARS) |->
         (int'(idx_ff) == int'(line_ff) * NUM_COLUMNS + int'(col_ff)))
      else $error("buffer index out of step with line and column");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(col_ff) < NUM_COLUMNS) && (int'(line_ff) < NUM_LINES))
      else $error("commit column or line beyond the display");

   a_last_only_on_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.last |-> cmd.emit)
      else $error("last flag without a transfer");

endmodule

[src/clcd_datapath.sv]
// Text buffer, cursor, transfer formatting and the result register.
module clcd_datapath import clcd_pkg::*; #(
   parameter int NUM_LINES   = 2,
   parameter int NUM_COLUMNS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  cmd_type                                      cmd,
   input  logic [(NUM_LINES > 1 ? $clog2(NUM_LINES) : 1)-1:0] cmd_line,
   input  logic [$clog2(NUM_LINES*NUM_COLUMNS)-1:0]     rd_addr,
   output logic                                         out_free,
   input  logic                                         font_tall,
   input  logic [7:0]                                   req_glyph,
   input  logic                                         req_row,
   input  logic [3:0]                                   req_col,
   input  logic                                         req_disp_on,
   input  logic                                         req_cur_on,
   input  logic                                         req_cur_blink,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic [1:0]                                   rsp_transfer_kind,
   output logic                                         rsp_reg_sel,
   output logic [7:0]                                   rsp_bus_value,
   output logic [2:0]                                   rsp_wait_code,
   output logic                                         rsp_last
);

   localparam int LW    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int CW    = $clog2(NUM_COLUMNS);
   localparam int DEPTH = NUM_LINES * NUM_COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   logic [LW-1:0]    cur_line_ff, cur_line_in;
   logic [CW-1:0]    cur_col_ff, cur_col_in;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic             vld_q_ff;
   logic             row_ff, disp_ff, curon_ff, blink_ff;
   logic [3:0]       col_req_ff;
   logic [AW:0]      pos_wide;
   logic [AW-1:0]    wr_addr;
   logic             wr_en;
   logic [7:0]       ram_q;
   logic [7:0]       char_q;
   logic [5:0]       user_col;
   logic [1:0]       user_line;
   xfer_type         xfer;
   logic             rsp_valid_ff;
   xfer_type         rsp_xfer_ff;
   logic             rsp_last_ff;

   function automatic logic [7:0] cursor_byte(logic [1:0] ln, logic [5:0] cl);
      logic [6:0] a;
      a = (ln[0] ? 7'h40 : 7'h00) + (ln[1] ? 7'(NUM_COLUMNS) : 7'h00) + {1'b0, cl};
      return CMD_SET_DDRAM | {1'b0, a};
   endfunction

   assign pos_wide = (AW+1)'(cur_line_ff) * (AW+1)'(NUM_COLUMNS) + (AW+1)'(cur_col_ff);
   assign wr_addr  = pos_wide[AW-1:0];
   assign wr_en    = cmd.put_char && (req_glyph != CHAR_CR)
                     && (req_glyph != CHAR_LF);

   always_comb begin
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      valid_in    = valid_ff;
      if (cmd.clear) begin
         cur_line_in = '0;
         cur_col_in  = '0;
         valid_in    = '0;
      end else if (cmd.put_char) begin
         if (req_glyph == CHAR_CR) begin
            cur_col_in = '0;
         end else if (req_glyph == CHAR_LF) begin
            cur_col_in = '0;
            if (cur_line_ff == LW'(NUM_LINES - 1)) begin
               cur_line_in = '0;
            end else begin
               cur_line_in = LW'(cur_line_ff + 1'b1);
            end
         end else begin
            valid_in[wr_addr] = 1'b1;
            if (cur_col_ff == CW'(NUM_COLUMNS - 1)) begin
               cur_col_in = '0;
            end else begin
               cur_col_in = CW'(cur_col_ff + 1'b1);
            end
         end
      end
   end

   clcd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_glyph),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign char_q = vld_q_ff ? ram_q : CHAR_SPACE;

   always_comb begin
      user_col = {2'b00, col_req_ff};
      if (user_col >= 6'(NUM_COLUMNS)) begin
         user_col = 6'(user_col - 6'(NUM_COLUMNS));
      end
      user_line = (NUM_LINES > 1) ? {1'b0, row_ff} : 2'b00;
   end

   always_comb begin
      xfer.kind      = KIND_BYTE;
      xfer.reg_sel   = RS_CMD;
      xfer.wait_code = WAIT_50US;
      xfer.bus_value = CMD_DISP_CTRL;
      case (cmd.sel)
         SEL_INIT:     xfer = init_xfer(cmd.init_step, font_tall, NUM_LINES > 1);
         SEL_LINE_CUR: xfer.bus_value = cursor_byte(2'(cmd_line), 6'd0);
         SEL_CHAR: begin
            xfer.reg_sel   = RS_DATA;
            xfer.bus_value = char_q;
         end
         SEL_RESTORE:  xfer.bus_value = cursor_byte(2'(cur_line_ff), 6'(cur_col_ff));
         SEL_DISP:     xfer.bus_value = CMD_DISP_CTRL | {5'b0, disp_ff, curon_ff, blink_ff};
         SEL_USER_CUR: xfer.bus_value = cursor_byte(user_line, user_col);
         default:      xfer.bus_value = CMD_DISP_CTRL;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_line_ff  <= '0;
         cur_col_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_line_ff <= cur_line_in;
         cur_col_ff  <= cur_col_in;
         valid_ff    <= valid_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         vld_q_ff <= valid_ff[rd_addr];
      end
      if (cmd.capture) begin
         row_ff     <= req_row;
         col_req_ff <= req_col;
         disp_ff    <= req_disp_on;
         curon_ff   <= req_cur_on;
         blink_ff   <= req_cur_blink;
      end
      if (cmd.emit) begin
         rsp_xfer_ff <= xfer;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_transfer_kind = rsp_xfer_ff.kind;
   assign rsp_reg_sel       = rsp_xfer_ff.reg_sel;
   assign rsp_bus_value     = rsp_xfer_ff.bus_value;
   assign rsp_wait_code     = rsp_xfer_ff.wait_code;
   assign rsp_last          = rsp_last_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_col_ff) < NUM_COLUMNS) && (int'(cur_line_ff) < NUM_LINES))
      else $error("buffer cursor beyond the display");

   a_clear_empties_buffer: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (valid_ff == '0) && (cur_col_ff == '0) && (cur_line_ff == '0))
      else $error("clear left buffer contents or cursor behind");

   a_rsp_held_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_xfer_ff) && $stable(rsp_last_ff)))
      else $error("transfer changed while waiting for acceptance");

endmodule

[src/character_lcd_text_console.sv]
// Top level of the character LCD text console: CSR port, sequencer and datapath.
//
//  channel  | handshake           | contents
//  ---------+---------------------+-----------------------------------------------
//  req      | req_valid/req_ready | request type, character, cursor target, flags
//  rsp      | rsp_valid/rsp_ready | one bus transfer: kind, RS, value, delay, last
//  csr      | APB-style, pready=1 | font_tall at byte address 0
//
// Put char and clear give no transfers. Every other request is accepted and then
// issues its transfers: commit gives NUM_LINES*(NUM_COLUMNS+1)+1 transfers, init
// twelve more, all through the single output register that the sequencer
// fills once per cycle. A stalled rsp_ready holds the sequence in place. Reset
// empties the text buffer at once through per-entry valid bits; no clearing
// pass is needed.
module character_lcd_text_console import clcd_pkg::*; #(
   parameter int NUM_LINES   = 2,
   parameter int NUM_COLUMNS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_glyph,
   input  logic        req_row,
   input  logic [3:0]  req_col,
   input  logic        req_disp_on,
   input  logic        req_cur_on,
   input  logic        req_cur_blink,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_transfer_kind,
   output logic        rsp_reg_sel,
   output logic [7:0]  rsp_bus_value,
   output logic [2:0]  rsp_wait_code,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int AW = $clog2(NUM_LINES*NUM_COLUMNS);

   cmd_type       cmd;
   logic          out_free;
   logic [LW-1:0] cmd_line;
   logic [AW-1:0] rd_addr;
   logic          font_tall_ff;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {31'b0, font_tall_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         font_tall_ff <= 1'b0;
      end else if (csr_wr && (csr_paddr[2] == 1'b0)) begin
         font_tall_ff <= csr_pwdata[0];
      end
   end

   clcd_ctrl #(
      .NUM_LINES   (NUM_LINES),
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .out_free  (out_free),
      .cmd       (cmd),
      .cmd_line  (cmd_line),
      .rd_addr   (rd_addr)
   );

   clcd_datapath #(
      .NUM_LINES   (NUM_LINES),
      .NUM_COLUMNS (NUM_COLUMNS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cmd_line          (cmd_line),
      .rd_addr           (rd_addr),
      .out_free          (out_free),
      .font_tall         (font_tall_ff),
      .req_glyph         (req_glyph),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_disp_on       (req_disp_on),
      .req_cur_on        (req_cur_on),
      .req_cur_blink     (req_cur_blink),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_transfer_kind (rsp_transfer_kind),
      .rsp_reg_sel       (rsp_reg_sel),
      .rsp_bus_value     (rsp_bus_value),
      .rsp_wait_code     (rsp_wait_code),
      .rsp_last          (rsp_last)
   );

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("request taken while a transfer sequence is running");

   a_config_write_lands: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && (csr_paddr[2] == 1'b0)) |=> (font_tall_ff == $past(csr_pwdata[0])))
      else $error("font register write lost");

   a_last_closes_request: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> !(rsp_valid && !req_ready && $stable(rsp_last)
         && rsp_last))
      else $error("final transfer repeated");

endmodule
